### design/lpht_pkg.sv
package lpht_pkg;

	localparam int SLOT_CAPACITY_DEF = 1024;
	localparam int KEY_BITS = 32;
	localparam int VALUE_BITS = 32;
	localparam int HASH_BITS = 32;
	localparam int ACTIVE_BITS = 11;
	localparam int SLOT_BITS = 10;
	localparam int ENTRY_BITS = 11;
	localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = 11'd1024;

	localparam logic [1:0] KIND_GET = 2'd0;
	localparam logic [1:0] KIND_PUT = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	typedef enum logic [2:0] {
		STAT_FOUND = 3'd0,
		STAT_INSERTED = 3'd1,
		STAT_UPDATED = 3'd2,
		STAT_NOT_FOUND = 3'd3,
		STAT_FULL = 3'd4,
		STAT_RESERVED = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_HASH,
		S_PROBE,
		S_RESP
	} state_t;

	typedef logic [ACTIVE_BITS-1:0] cfg_data_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [KEY_BITS-1:0] key;
		logic [VALUE_BITS-1:0] value;
		logic [HASH_BITS-1:0] home_hash;
	} req_t;

	typedef struct packed {
		status_t status;
		logic [VALUE_BITS-1:0] found_value;
		logic [SLOT_BITS-1:0] slot_index;
		logic [ENTRY_BITS-1:0] entry_total;
	} rsp_t;

	typedef struct packed {
		logic used;
		logic [KEY_BITS-1:0] key;
		logic [VALUE_BITS-1:0] value;
	} entry_t;

endpackage

### design/lpht_chan_if.sv
interface lpht_chan_if #(
	parameter type payload_t = logic
) ();
	logic valid;
	logic ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### design/lpht_ram.sv
module lpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

### design/lpht_mod_unit.sv
module lpht_mod_unit #(
	parameter int CNT_W = 11
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [lpht_pkg::HASH_BITS-1:0] dividend,
	input logic [CNT_W-1:0] divisor,
	output logic done,
	output logic [CNT_W-1:0] rem
);
	import lpht_pkg::*;

	localparam int DIGIT_BITS = 4;
	localparam int DIGITS = HASH_BITS / DIGIT_BITS;
	localparam int STEP_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	logic busy_q;
	logic done_q;
	logic [STEP_W-1:0] step_q;
	logic [HASH_BITS-1:0] dvd_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] rem_d;

	// restoring remainder, DIGIT_BITS dividend bits per cycle
	always_comb begin
		logic [CNT_W:0] t;
		logic [CNT_W-1:0] r;
		r = rem_q;
		for (int i = 0; i < DIGIT_BITS; i++) begin
			t = {r, dvd_q[HASH_BITS-1-i]};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
			end
			r = t[CNT_W-1:0];
		end
		rem_d = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(DIGITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << DIGIT_BITS;
			rem_q <= rem_d;
		end
	end

	assign done = done_q;
	assign rem = rem_q;
endmodule

### design/linear_probe_hash_table_core.sv
// channel  modport  payload                                      request
// req      sink     kind, key, value, home_hash                  get, put or clear
// rsp      source   status, found_value, slot_index, entry_total one per req
// cfg      sink     active_slots (11 b)                          always ready
//
// Get/put: accept, home slot (radix-16 remainder unit, then the home read), then each probed
// slot in turn (one RAM read port, registered), then the result.
// Clear: a sweep through the slot RAM, then the result.
// After reset the same sweep runs before req is ready.
// A stalled rsp holds the finished result; the next req is taken meanwhile.
module linear_probe_hash_table_core #(
	parameter int SLOT_CAPACITY = lpht_pkg::SLOT_CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	lpht_chan_if.sink req,
	lpht_chan_if.source rsp,
	lpht_chan_if.sink cfg
);
	import lpht_pkg::*;

	localparam int IW = $clog2(SLOT_CAPACITY);
	localparam int CW = $clog2(SLOT_CAPACITY + 1);
	localparam int WW = (CW > ACTIVE_BITS) ? CW : ACTIVE_BITS;
	localparam int EW = $bits(entry_t);

	state_t state_q, state_d;
	logic [IW-1:0] sweep_q;
	logic clr_q;
	logic [CW-1:0] count_q;
	cfg_data_t active_q;
	logic rsp_valid_q;
	rsp_t rsp_data_q;

	req_t op_q;
	logic [IW-1:0] slot_q;
	logic [CW-1:0] probes_q;
	rsp_t res_q;

	logic accept;
	logic out_free;
	logic sweep_last;
	logic is_put;
	logic [WW-1:0] act_w;
	logic [WW-1:0] eff_w;
	logic [CW-1:0] eff_n;
	logic [IW-1:0] home;
	logic [IW-1:0] next_slot;
	logic [CW-1:0] next_probes;
	logic exhausted;
	logic hit_empty;
	logic hit_key;

	logic mod_start;
	logic mod_done;
	logic [CW-1:0] mod_rem;

	logic ram_we;
	logic [IW-1:0] ram_waddr;
	entry_t ram_wdata;
	logic [IW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;
	entry_t ent;

	assign accept = req.valid & req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_data_q;

	assign sweep_last = (sweep_q == IW'(SLOT_CAPACITY - 1));
	assign is_put = (op_q.kind == KIND_PUT);

	always_comb begin
		act_w = WW'(active_q);
		if (act_w == '0) begin
			eff_w = WW'(1);
		end else if (act_w > WW'(SLOT_CAPACITY)) begin
			eff_w = WW'(SLOT_CAPACITY);
		end else begin
			eff_w = act_w;
		end
		eff_n = CW'(eff_w);
	end

	assign home = IW'(mod_rem);
	assign next_slot = ((CW'(slot_q) + CW'(1)) == eff_n) ? '0 : slot_q + IW'(1);
	assign next_probes = probes_q + CW'(1);
	assign exhausted = (next_probes == eff_n);
	assign ent = ram_rdata;
	assign hit_empty = !ent.used;
	assign hit_key = ent.used && (ent.key == op_q.key);

	lpht_mod_unit #(
		.CNT_W(CW)
	) u_mod (
		.clk(clk),
		.arst_n(arst_n),
		.start(mod_start),
		.dividend(req.data.home_hash),
		.divisor(eff_n),
		.done(mod_done),
		.rem(mod_rem)
	);

	lpht_ram #(
		.WIDTH(EW),
		.DEPTH(SLOT_CAPACITY)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = '{used: 1'b1, key: op_q.key, value: op_q.value};
		ram_raddr = slot_q;
		mod_start = 1'b0;
		case (state_q)
			S_SWEEP: begin
				ram_we = 1'b1;
				ram_waddr = sweep_q;
				ram_wdata = '0;
				if (sweep_last) begin
					state_d = clr_q ? S_RESP : S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (req.data.kind == KIND_CLEAR) begin
						state_d = S_SWEEP;
					end else if (req.data.key == '1) begin
						state_d = S_RESP;
					end else begin
						mod_start = 1'b1;
						state_d = S_HASH;
					end
				end
			end
			S_HASH: begin
				if (mod_done) begin
					ram_raddr = home;
					state_d = S_PROBE;
				end
			end
			S_PROBE: begin
				if (hit_empty || hit_key) begin
					ram_we = is_put;
					state_d = S_RESP;
				end else begin
					ram_raddr = next_slot;
					if (exhausted) begin
						state_d = S_RESP;
					end
				end
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			clr_q <= 1'b0;
			count_q <= '0;
			active_q <= ACTIVE_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				active_q <= cfg.data;
			end
			if (state_q == S_SWEEP) begin
				sweep_q <= sweep_q + IW'(1);
			end
			if (accept) begin
				clr_q <= (req.data.kind == KIND_CLEAR);
				if (req.data.kind == KIND_CLEAR) begin
					sweep_q <= '0;
					count_q <= '0;
				end
			end
			if (state_q == S_PROBE && hit_empty && is_put) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == S_RESP && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= req.data;
			res_q.status <= (req.data.kind == KIND_CLEAR) ? STAT_FOUND : STAT_RESERVED;
			res_q.found_value <= '0;
			res_q.slot_index <= '0;
			res_q.entry_total <= (req.data.kind == KIND_CLEAR) ? '0 : ENTRY_BITS'(count_q);
		end
		if (state_q == S_HASH && mod_done) begin
			slot_q <= home;
			probes_q <= '0;
		end
		if (state_q == S_PROBE) begin
			if (hit_empty) begin
				res_q.status <= is_put ? STAT_INSERTED : STAT_NOT_FOUND;
				res_q.slot_index <= is_put ? SLOT_BITS'(slot_q) : '0;
				res_q.entry_total <= is_put ? ENTRY_BITS'(count_q + CW'(1))
					: ENTRY_BITS'(count_q);
			end else if (hit_key) begin
				res_q.status <= is_put ? STAT_UPDATED : STAT_FOUND;
				res_q.found_value <= is_put ? '0 : ent.value;
				res_q.slot_index <= SLOT_BITS'(slot_q);
				res_q.entry_total <= ENTRY_BITS'(count_q);
			end else begin
				slot_q <= next_slot;
				probes_q <= next_probes;
				if (exhausted) begin
					res_q.status <= is_put ? STAT_FULL : STAT_NOT_FOUND;
					res_q.entry_total <= ENTRY_BITS'(count_q);
				end
			end
		end
		if (state_q == S_RESP && out_free) begin
			rsp_data_q <= res_q;
		end
	end
endmodule

### test/lpht_table_checker.sv
module lpht_table_checker #(
	parameter int SLOT_CAPACITY = lpht_pkg::SLOT_CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input lpht_pkg::req_t req_data,
	input logic rsp_valid,
	input logic rsp_ready,
	input lpht_pkg::rsp_t rsp_data,
	input logic cfg_valid,
	input logic cfg_ready,
	input lpht_pkg::cfg_data_t cfg_data,
	output int fail_count,
	output int outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import lpht_pkg::*;

	logic slot_taken [SLOT_CAPACITY];
	logic [KEY_BITS-1:0] slot_key [SLOT_CAPACITY];
	logic [VALUE_BITS-1:0] slot_value [SLOT_CAPACITY];
	logic [ENTRY_BITS-1:0] occupancy;
	cfg_data_t active_slots;
	rsp_t owed_rsp [$];

	initial begin
		active_slots = ACTIVE_RESET;
		occupancy = '0;
		foreach (slot_taken[j]) slot_taken[j] = 1'b0;
		fail_count = 0;
		outstanding = 0;
	end

	function automatic int unsigned probe_span();
		if (active_slots == 0) return 1;
		if (active_slots > SLOT_CAPACITY) return SLOT_CAPACITY;
		return int'(active_slots);
	endfunction

	// 0 key hit, 1 empty slot, 2 every slot probed
	function automatic rsp_t run_request(req_t r);
		rsp_t o;
		int unsigned n;
		int unsigned s;
		int outcome;
		o = '0;
		o.status = STAT_FOUND;
		if (r.kind == KIND_CLEAR) begin
			foreach (slot_taken[j]) slot_taken[j] = 1'b0;
			occupancy = '0;
		end else if (&r.key) begin
			o.status = STAT_RESERVED;
		end else begin
			n = probe_span();
			s = r.home_hash % n;
			outcome = 2;
			for (int i = 0; i < n && outcome == 2; i++) begin
				if (!slot_taken[s]) outcome = 1;
				else if (slot_key[s] == r.key) outcome = 0;
				else s = (s + 1 == n) ? 0 : s + 1;
			end
			if (r.kind == KIND_PUT) begin
				case (outcome)
					0: begin
						slot_value[s] = r.value;
						o.status = STAT_UPDATED;
						o.slot_index = s[SLOT_BITS-1:0];
					end
					1: begin
						slot_taken[s] = 1'b1;
						slot_key[s] = r.key;
						slot_value[s] = r.value;
						occupancy = occupancy + 1'b1;
						o.status = STAT_INSERTED;
						o.slot_index = s[SLOT_BITS-1:0];
					end
					default: o.status = STAT_FULL;
				endcase
			end else if (outcome == 0) begin
				o.status = STAT_FOUND;
				o.found_value = slot_value[s];
				o.slot_index = s[SLOT_BITS-1:0];
			end else begin
				o.status = STAT_NOT_FOUND;
			end
		end
		o.entry_total = occupancy;
		return o;
	endfunction

	always @(posedge clk) begin : watch
		rsp_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) active_slots = cfg_data;
			if (req_valid && req_ready) owed_rsp.push_back(run_request(req_data));
			if (rsp_valid && rsp_ready) begin
				if (owed_rsp.size() == 0) begin
					$display("%0t ns: result with no request waiting: %s",
						$time, "expected none");
					$display("%0t ns: got status %0d value %h slot %0d total %0d",
						$time, rsp_data.status, rsp_data.found_value,
						rsp_data.slot_index, rsp_data.entry_total);
					fail_count++;
				end else begin
					want = owed_rsp.pop_front();
					if (rsp_data.status !== want.status) begin
						$display("%0t ns: status expected %0d got %0d",
							$time, want.status, rsp_data.status);
						fail_count++;
					end
					if (rsp_data.found_value !== want.found_value) begin
						$display("%0t ns: found_value expected %h got %h",
							$time, want.found_value, rsp_data.found_value);
						fail_count++;
					end
					if (rsp_data.slot_index !== want.slot_index) begin
						$display("%0t ns: slot_index expected %0d got %0d",
							$time, want.slot_index, rsp_data.slot_index);
						fail_count++;
					end
					if (rsp_data.entry_total !== want.entry_total) begin
						$display("%0t ns: entry_total expected %0d got %0d",
							$time, want.entry_total, rsp_data.entry_total);
						fail_count++;
					end
				end
			end
			outstanding <= owed_rsp.size();
		end
	end

endmodule

### test/linear_probe_hash_table_core_test.sv
module linear_probe_hash_table_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import lpht_pkg::*;

	// kind 3 behaves as a get
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int POOL_SIZE = 40;

	logic clk;
	logic arst_n;
	int fail_count;
	int outstanding;
	int hold_off_cycles = 0;
	bit steady = 1'b0;

	logic [KEY_BITS-1:0] pool_key [POOL_SIZE];
	logic [HASH_BITS-1:0] pool_hash [POOL_SIZE];
	int phase_slots [12] = '{3, 1, 16, 2047, 2, 37, 0, 1024, 7, 64, 5, 200};

	lpht_chan_if #(.payload_t(req_t)) req ();
	lpht_chan_if #(.payload_t(rsp_t)) rsp ();
	lpht_chan_if #(.payload_t(cfg_data_t)) cfg ();

	linear_probe_hash_table_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

	lpht_table_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.req_data(req.data),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.rsp_data(rsp.data),
		.cfg_valid(cfg.valid),
		.cfg_ready(cfg.ready),
		.cfg_data(cfg.data),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				rsp.ready <= 1'b0;
				hold_off_cycles--;
			end else begin
				rsp.ready <= steady || ($urandom_range(0, 99) >= 17);
			end
		end
	end

	function automatic req_t pack_req(logic [1:0] kind, logic [KEY_BITS-1:0] key,
			logic [VALUE_BITS-1:0] value, logic [HASH_BITS-1:0] hash);
		req_t r;
		r.kind = kind;
		r.key = key;
		r.value = value;
		r.home_hash = hash;
		return r;
	endfunction

	task automatic send_req(input req_t r);
		if (!steady && $urandom_range(0, 99) < 17) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.data <= r;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic set_active(input cfg_data_t v);
		wait_drained();
		repeat (4) @(negedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= v;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic refill_pool();
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_key[i] = $urandom;
			if (&pool_key[i]) pool_key[i] = '0;
			// half the hashes land in a tight cluster to force long probes
			pool_hash[i] = $urandom_range(0, 1) ? $urandom
				: (($urandom & 32'hFFFF_FC00) | $urandom_range(0, 7));
		end
	endtask

	task automatic random_item(input int pool_n);
		req_t r;
		int pick;
		int sel;
		sel = $urandom_range(0, 99);
		pick = $urandom_range(0, pool_n - 1);
		r.key = pool_key[pick];
		r.home_hash = ($urandom_range(0, 9) == 0) ? $urandom : pool_hash[pick];
		r.value = $urandom;
		if (sel < 2) begin
			r.kind = KIND_CLEAR;
		end else if (sel < 6) begin
			r.kind = $urandom_range(0, 1) ? KIND_PUT : KIND_GET;
			r.key = '1;
		end else if (sel < 10) begin
			r.kind = KIND_SPARE;
		end else if (sel < 55) begin
			r.kind = KIND_PUT;
		end else begin
			r.kind = KIND_GET;
		end
		send_req(r);
	endtask

	initial begin
		cfg_data_t v;
		int eff;
		int pool_n;
		int n_items;
		req.valid = 1'b0;
		req.data = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		send_req(pack_req(KIND_GET, 32'h0, 32'h0, 32'h0));
		send_req(pack_req(KIND_PUT, 32'h0, 32'h0, 32'h0));
		send_req(pack_req(KIND_PUT, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		// same home as the last slot, wraps past slot 0
		send_req(pack_req(KIND_PUT, 32'h1234_5678, 32'hA5A5_A5A5, 32'h0000_03FF));
		send_req(pack_req(KIND_GET, 32'h1234_5678, 32'h0, 32'hFFFF_FFFF));
		send_req(pack_req(KIND_GET, 32'hFFFF_FFFE, 32'h0, 32'hFFFF_FFFF));
		send_req(pack_req(KIND_PUT, 32'h0, 32'hFFFF_FFFF, 32'h0));
		send_req(pack_req(KIND_SPARE, 32'h0, 32'h0, 32'h0));
		send_req(pack_req(KIND_GET, 32'h0, 32'h0, 32'h5));
		send_req(pack_req(KIND_GET, 32'hFFFF_FFFF, 32'h0, 32'h0));
		send_req(pack_req(KIND_PUT, 32'hFFFF_FFFF, 32'h1, 32'h0));
		send_req(pack_req(KIND_CLEAR, 32'h0, 32'h0, 32'h0));
		send_req(pack_req(KIND_GET, 32'h0, 32'h0, 32'h0));

		// zero slots acts as one: second distinct key finds the table full
		set_active('0);
		send_req(pack_req(KIND_PUT, 32'h55AA_55AA, 32'h1, $urandom));
		send_req(pack_req(KIND_PUT, 32'hAA55_AA55, 32'h2, $urandom));
		send_req(pack_req(KIND_PUT, 32'h55AA_55AA, 32'h3, $urandom));
		send_req(pack_req(KIND_GET, 32'hAA55_AA55, 32'h0, $urandom));
		send_req(pack_req(KIND_GET, 32'h55AA_55AA, 32'h0, $urandom));

		// above capacity acts as capacity; old entry is still in slot 0
		set_active('1);
		send_req(pack_req(KIND_GET, 32'h55AA_55AA, 32'h0, 32'h0));
		send_req(pack_req(KIND_PUT, 32'h1, 32'h2, 32'h7FF));
		send_req(pack_req(KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

		for (int p = 0; p < 12; p++) begin
			v = (p == 11) ? cfg_data_t'($urandom_range(0, 2047)) : cfg_data_t'(phase_slots[p]);
			set_active(v);
			eff = (v == 0) ? 1 : ((v > SLOT_CAPACITY_DEF) ? SLOT_CAPACITY_DEF : int'(v));
			pool_n = (eff > 26) ? POOL_SIZE : eff + eff / 2 + 1;
			n_items = (eff > 100) ? 40 : 70;
			refill_pool();
			steady = (p == 3);
			for (int i = 0; i < n_items; i++) begin
				if (p == 2 && i == 20) hold_off_cycles = 300;
				if (p == 2 && i == 45) wait_drained();
				random_item(pool_n);
			end
		end
		steady = 1'b0;

		wait_drained();
		repeat (20) @(negedge clk);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
